// File: rtl/core/pcrc_pkg.sv
package pcrc_pkg;

    // Default table depth.
    localparam int MAX_NODES_DEF = 64;

    localparam int ID_W     = 16;
    localparam int PARENT_W = 17;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;

    typedef logic [ID_W-1:0]            node_id_t;
    typedef logic signed [PARENT_W-1:0] parent_t;

    // A parent of minus one marks a node without a parent.
    localparam parent_t PARENT_NONE = '1;
    localparam parent_t ROOT_ID     = '0;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_MISSING = 2'd2,
        ST_CYCLE   = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_WALK = 1'b1
    } walk_state_t;

    // One table entry as it moves from cell to cell. A shadowed entry has an
    // id that an older entry already carries, so it can never be the first match.
    typedef struct packed {
        node_id_t id;
        parent_t  parent;
        logic     shadow;
    } entry_t;

    // Result of one parallel lookup across the row.
    typedef struct packed {
        logic    hit;
        parent_t parent;
    } lookup_t;

endpackage

// File: rtl/core/pcrc_cell.sv
module pcrc_cell (
    input  logic              aclk,
    input  logic              shift_en,
    input  logic              valid,
    input  pcrc_pkg::entry_t  entry_in,
    input  pcrc_pkg::parent_t key,
    output pcrc_pkg::entry_t  entry_out,
    output logic              match,
    output pcrc_pkg::parent_t parent_sel
);
    import pcrc_pkg::*;

    entry_t entry_reg;

    // Entries advance one cell on every append that is not dropped; no reset is needed.
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            entry_reg <= entry_in;
        end
    end

    assign entry_out  = entry_reg;
    assign match      = valid && !entry_reg.shadow &&
                        (key == parent_t'({1'b0, entry_reg.id}));
    assign parent_sel = match ? entry_reg.parent : '0;

endmodule

// File: rtl/core/pcrc_chain.sv
module pcrc_chain #(
    parameter int MAX_NODES = pcrc_pkg::MAX_NODES_DEF,
    parameter int CW        = $clog2(MAX_NODES + 1)
) (
    input  logic              aclk,
    input  logic              shift_en,
    input  logic [CW-1:0]     count,
    input  pcrc_pkg::node_id_t new_id,
    input  pcrc_pkg::parent_t new_parent,
    input  pcrc_pkg::parent_t key,
    output pcrc_pkg::lookup_t lookup
);
    import pcrc_pkg::*;

    entry_t  link  [MAX_NODES+1];
    logic    match [MAX_NODES];
    parent_t psel  [MAX_NODES];

    // The newest entry enters at cell 0; it is shadowed when the current key
    // (its own id during an append) already matches a live entry.
    assign link[0] = '{id: new_id, parent: new_parent, shadow: lookup.hit};

    for (genvar k = 0; k < MAX_NODES; k++) begin : g_cell
        pcrc_cell u_cell (
            .aclk       (aclk),
            .shift_en   (shift_en),
            .valid      (CW'(k) < count),
            .entry_in   (link[k]),
            .key        (key),
            .entry_out  (link[k+1]),
            .match      (match[k]),
            .parent_sel (psel[k])
        );
    end

    // At most one live, unshadowed cell can match, so an OR merge suffices.
    always_comb begin
        lookup = '0;
        for (int k = 0; k < MAX_NODES; k++) begin
            lookup.hit    = lookup.hit | match[k];
            lookup.parent = lookup.parent | psel[k];
        end
    end

endmodule

// File: rtl/core/parent_chain_root_check.sv
// Channel  | Handshake         | Payload
// ---------+-------------------+--------------------------------------------
// input    | s_valid / s_ready | s_op, s_node_id, s_parent_ref
// result   | m_valid / m_ready | m_status, m_inside_res
//
// Clear and append transactions complete while idle. A query enters the walk,
// which makes one parallel id match per parent hop and then settles the result;
// the hops are bounded by the entry count, so there are at most MAX_NODES of them.
// A result waiting on m_ready does not block the input; a following query's walk
// holds in its final cycle, with s_ready low, until that result is taken.
// Reset is synchronous and active low; it empties the table and drops m_valid.
module parent_chain_root_check #(
    parameter int MAX_NODES = pcrc_pkg::MAX_NODES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_op,
    input  pcrc_pkg::node_id_t   s_node_id,
    input  pcrc_pkg::parent_t    s_parent_ref,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_status,
    output logic                 m_inside_res
);
    import pcrc_pkg::*;

    localparam int CW = $clog2(MAX_NODES + 1);

    walk_state_t   state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] hop_reg, hop_next;
    parent_t       cur_reg, cur_next;
    logic          m_valid_reg, m_valid_next;
    status_t       status_reg, status_next;
    logic          inside_reg, inside_next;

    logic          shift_en;
    parent_t       key;
    lookup_t       lookup;
    logic          out_free;
    logic          finish;
    status_t       fin_status;
    logic          fin_inside;

    pcrc_chain #(
        .MAX_NODES (MAX_NODES),
        .CW        (CW)
    ) u_chain (
        .aclk       (aclk),
        .shift_en   (shift_en),
        .count      (count_reg),
        .new_id     (s_node_id),
        .new_parent (s_parent_ref),
        .key        (key),
        .lookup     (lookup)
    );

    // While idle the row is searched with the incoming id, so that an append
    // learns whether its id is already present. During a walk it is searched
    // with the current node.
    assign key      = (state_reg == S_IDLE) ? parent_t'({1'b0, s_node_id}) : cur_reg;
    assign out_free = !m_valid_reg || m_ready;

    // The checks of one hop, in the order the walk makes them.
    always_comb begin
        finish     = 1'b1;
        fin_status = ST_OK;
        fin_inside = 1'b0;
        if (count_reg == '0) begin
            fin_status = ST_EMPTY;
        end else if (cur_reg == ROOT_ID) begin
            fin_inside = 1'b1;
        end else if (hop_reg == count_reg) begin
            fin_status = ST_CYCLE;
        end else if (!lookup.hit) begin
            fin_status = ST_MISSING;
        end else if (lookup.parent == PARENT_NONE) begin
            fin_status = ST_OK;
        end else begin
            finish = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hop_reg    <= hop_next;
        cur_reg    <= cur_next;
        status_reg <= status_next;
        inside_reg <= inside_next;
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        hop_next     = hop_reg;
        cur_next     = cur_reg;
        m_valid_next = m_valid_reg && !m_ready;
        status_next  = status_reg;
        inside_next  = inside_reg;
        shift_en     = 1'b0;
        s_ready      = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    case (op_t'(s_op))
                        OP_CLEAR: begin
                            count_next = '0;
                        end
                        OP_APPEND: begin
                            // An append to a full table is dropped.
                            if (count_reg < CW'(MAX_NODES)) begin
                                shift_en   = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_QUERY: begin
                            cur_next   = parent_t'({1'b0, s_node_id});
                            hop_next   = '0;
                            state_next = S_WALK;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (finish) begin
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        status_next  = fin_status;
                        inside_next  = fin_inside;
                        state_next   = S_IDLE;
                    end
                end else begin
                    cur_next = lookup.parent;
                    hop_next = hop_reg + 1'b1;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = status_reg;
    assign m_inside_res = inside_reg;

`ifndef SYNTHESIS
    a_inside_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_inside_res || m_status == ST_OK))
        else $error("inside flag set on an error result");

    a_hop_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_WALK |-> hop_reg <= count_reg)
        else $error("walk ran past the entry count");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_NODES))
        else $error("entry count beyond table depth");

    a_table_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_WALK |=> $stable(count_reg))
        else $error("table changed during a walk");
`endif

endmodule
